// ----- hw/rtl/textured_half_lambert_shade_defines.svh -----
// ----------------------------------------------------------------------------
// textured half-lambert shader assertion macros
// shared property forms for the port checker, clocked on clock
// ----------------------------------------------------------------------------
`ifndef TEXTURED_HALF_LAMBERT_SHADE_DEFINES_SVH
`define TEXTURED_HALF_LAMBERT_SHADE_DEFINES_SVH

// same-cycle implication, off during reset
`define THLS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define THLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// state in the cycle after reset
`define THLS_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/thls_pkg.sv -----
// ----------------------------------------------------------------------------
// thls_pkg
// types, codes and helpers shared by the textured half-lambert shader
// ----------------------------------------------------------------------------
package thls_pkg;

   localparam int VEC_W    = 16;
   localparam int COORD_W  = 17;
   localparam int BYTE_W   = 8;
   localparam int INT_W    = 15;
   localparam int DOT_W    = 34;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int DIM_REG_W = 9;

   // item kinds on the request tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SHADE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_W   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_H   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_ON  = 3'd5;

   localparam logic signed [VEC_W-1:0] LIGHT_Z_RST = 16'sd16384;

   // 1.0 in q2.28
   localparam logic signed [DOT_W-1:0] DOT_ONE = 34'sd268435456;

   // intensity taps from stage two to the texel read stage
   localparam int INT_TAPS = 5;
   // request payload taps from acceptance to the memory stage
   localparam int WR_TAPS  = 5;
   // control taps from acceptance to the texel read stage
   localparam int CTL_TAPS = 6;

   typedef struct packed {
      logic valid;
      logic shade;
   } ctl_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [VEC_W-1:0] addr;
      rgb_type          rgb;
   } wr_type;

   // byte times q1.14 intensity, truncated
   function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] b,
                                                     input logic [INT_W-1:0]  i);
      logic [BYTE_W+INT_W-1:0] p;
      p = (BYTE_W+INT_W)'(b) * (BYTE_W+INT_W)'(i);
      return p[14 +: BYTE_W];
   endfunction

endpackage

// ----- hw/rtl/thls_csr.sv -----
// ----------------------------------------------------------------------------
// thls_csr
// light direction, texture size and texture enable registers, sizes kept clamped
// ----------------------------------------------------------------------------
module thls_csr #(
   parameter int TEX_DIM_MAX = 256
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   input  logic [thls_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [thls_pkg::CSR_DAT_W-1:0]           csr_data,
   output logic signed [thls_pkg::VEC_W-1:0]        light_x,
   output logic signed [thls_pkg::VEC_W-1:0]        light_y,
   output logic signed [thls_pkg::VEC_W-1:0]        light_z,
   output logic [$clog2(TEX_DIM_MAX+1)-1:0]         tex_w,
   output logic [$clog2(TEX_DIM_MAX+1)-1:0]         tex_h,
   output logic                                     tex_on
);

   localparam int DIM_W   = $clog2(TEX_DIM_MAX + 1);
   localparam int DIM_RST = (TEX_DIM_MAX < 256) ? TEX_DIM_MAX : 256;

   logic signed [thls_pkg::VEC_W-1:0] light_x_ff, light_y_ff, light_z_ff;
   logic [DIM_W-1:0]                  tex_w_ff, tex_h_ff;
   logic                              tex_on_ff;
   logic [DIM_W-1:0]                  dim_in;

   function automatic logic [DIM_W-1:0] clamp_dim(
      input logic [thls_pkg::DIM_REG_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         return DIM_W'(1);
      end else if (v32 > 32'(TEX_DIM_MAX)) begin
         return DIM_W'(TEX_DIM_MAX);
      end
      return DIM_W'(v);
   endfunction

   assign dim_in = clamp_dim(csr_data[thls_pkg::DIM_REG_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= thls_pkg::LIGHT_Z_RST;
         tex_w_ff   <= DIM_W'(DIM_RST);
         tex_h_ff   <= DIM_W'(DIM_RST);
         tex_on_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            thls_pkg::REG_LIGHT_X: light_x_ff <= csr_data;
            thls_pkg::REG_LIGHT_Y: light_y_ff <= csr_data;
            thls_pkg::REG_LIGHT_Z: light_z_ff <= csr_data;
            thls_pkg::REG_TEX_W:   tex_w_ff   <= dim_in;
            thls_pkg::REG_TEX_H:   tex_h_ff   <= dim_in;
            thls_pkg::REG_TEX_ON:  tex_on_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign light_x = light_x_ff;
   assign light_y = light_y_ff;
   assign light_z = light_z_ff;
   assign tex_w   = tex_w_ff;
   assign tex_h   = tex_h_ff;
   assign tex_on  = tex_on_ff;

endmodule

// ----- hw/rtl/thls_light.sv -----
// ----------------------------------------------------------------------------
// thls_light
// normal dot light, clamp to [0,1] and half-lambert intensity in q1.14
// ----------------------------------------------------------------------------
module thls_light (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [thls_pkg::VEC_W-1:0]    normal_x,
   input  logic signed [thls_pkg::VEC_W-1:0]    normal_y,
   input  logic signed [thls_pkg::VEC_W-1:0]    normal_z,
   input  logic signed [thls_pkg::VEC_W-1:0]    light_x,
   input  logic signed [thls_pkg::VEC_W-1:0]    light_y,
   input  logic signed [thls_pkg::VEC_W-1:0]    light_z,
   output logic [thls_pkg::INT_W-1:0]           inten
);

   localparam int PROD_W = 2 * thls_pkg::VEC_W;
   localparam int DOT_W  = thls_pkg::DOT_W;

   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [DOT_W-1:0]  dot;
   logic [28:0]              m_clamp;
   logic [29:0]              biased;
   logic [thls_pkg::INT_W-1:0] inten_in;
   logic [thls_pkg::INT_W-1:0] inten_ff [thls_pkg::INT_TAPS];

   // stage one: three products
   always_comb begin
      px_in = normal_x * light_x;
      py_in = normal_y * light_y;
      pz_in = normal_z * light_z;
   end

   // stage two: sum, clamp and bias
   always_comb begin
      dot = DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);
      if (dot < 0) begin
         m_clamp = '0;
      end else if (dot > thls_pkg::DOT_ONE) begin
         m_clamp = thls_pkg::DOT_ONE[28:0];
      end else begin
         m_clamp = dot[28:0];
      end
      biased   = 30'(m_clamp) + 30'(thls_pkg::DOT_ONE[28:0]);
      inten_in = biased[15 +: thls_pkg::INT_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff       <= px_in;
         py_ff       <= py_in;
         pz_ff       <= pz_in;
         inten_ff[0] <= inten_in;
         for (int k = 1; k < thls_pkg::INT_TAPS; k++) begin
            inten_ff[k] <= inten_ff[k-1];
         end
      end
   end

   assign inten = inten_ff[thls_pkg::INT_TAPS-1];

endmodule

// ----- hw/rtl/thls_addr.sv -----
// ----------------------------------------------------------------------------
// thls_addr
// nearest texel address: scale, saturate, linearise, wrap to store size
// ----------------------------------------------------------------------------
module thls_addr #(
   parameter int TEX_DIM_MAX = 256,
   parameter int TEX_TEXELS  = 65536
) (
   input  logic                                           clock,
   input  logic                                           en,
   input  logic [thls_pkg::COORD_W-1:0]                   coord_u,
   input  logic [thls_pkg::COORD_W-1:0]                   coord_v,
   input  logic [$clog2(TEX_DIM_MAX+1)-1:0]               tex_w,
   input  logic [$clog2(TEX_DIM_MAX+1)-1:0]               tex_h,
   output logic [((TEX_TEXELS > 1) ? $clog2(TEX_TEXELS) : 1)-1:0] rd_addr
);

   localparam int DIM_W  = $clog2(TEX_DIM_MAX + 1);
   localparam int ADDR_W = (TEX_TEXELS > 1) ? $clog2(TEX_TEXELS) : 1;
   localparam int LOG_T  = $clog2(TEX_TEXELS);
   localparam int CU_W   = thls_pkg::COORD_W + DIM_W;
   localparam int LIN_W  = 2 * DIM_W;
   localparam int SHIFT  = LIN_W + LOG_T;
   localparam int RW     = LIN_W + 2;
   localparam int PW     = LIN_W + RW;
   localparam int TW     = LOG_T + 1;
   localparam int QT_W   = LIN_W + TW;
   localparam longint RECIP =
      ((longint'(1) << SHIFT) + longint'(TEX_TEXELS) - 1) / longint'(TEX_TEXELS);

   logic [CU_W-1:0]   cu_ff, cv_ff, cu_in, cv_in;
   logic [DIM_W:0]    ci, ri;
   logic [DIM_W-1:0]  w_last, h_last;
   logic [DIM_W-1:0]  col_ff, row_ff, col_in, row_in;
   logic [LIN_W-1:0]  lin_ff, lin_in, lin4_ff;
   logic [PW-1:0]     prod;
   logic [LIN_W-1:0]  q_ff, q_in;
   logic [QT_W-1:0]   diff;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // stage one: coordinate times size
   always_comb begin
      cu_in = CU_W'(coord_u) * CU_W'(tex_w);
      cv_in = CU_W'(coord_v) * CU_W'(tex_h);
   end

   // stage two: saturate to last column and row
   always_comb begin
      ci     = cu_ff[16 +: DIM_W+1];
      ri     = cv_ff[16 +: DIM_W+1];
      w_last = tex_w - DIM_W'(1);
      h_last = tex_h - DIM_W'(1);
      col_in = (ci > {1'b0, w_last}) ? w_last : ci[DIM_W-1:0];
      row_in = (ri > {1'b0, h_last}) ? h_last : ri[DIM_W-1:0];
   end

   // stage three: row * width + column
   assign lin_in = LIN_W'(row_ff) * LIN_W'(tex_w) + LIN_W'(col_ff);

   // stage four: quotient by reciprocal
   always_comb begin
      prod = PW'(lin_ff) * PW'(RECIP);
      q_in = LIN_W'(prod >> SHIFT);
   end

   // stage five: remainder
   always_comb begin
      diff    = QT_W'(lin4_ff) - QT_W'(q_ff) * QT_W'(TEX_TEXELS);
      addr_in = diff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cu_ff   <= cu_in;
         cv_ff   <= cv_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         lin_ff  <= lin_in;
         lin4_ff <= lin_ff;
         q_ff    <= q_in;
         addr_ff <= addr_in;
      end
   end

   assign rd_addr = addr_ff;

endmodule

// ----- hw/rtl/thls_tex_mem.sv -----
// ----------------------------------------------------------------------------
// thls_tex_mem
// single-port texel store, one registered read per enabled cycle, plus one write on a load
// ----------------------------------------------------------------------------
module thls_tex_mem #(
   parameter int TEX_TEXELS = 65536
) (
   input  logic                                                   clock,
   input  logic                                                   en,
   input  thls_pkg::ctl_type                                      ctl,
   input  thls_pkg::wr_type                                       wr,
   input  logic [((TEX_TEXELS > 1) ? $clog2(TEX_TEXELS) : 1)-1:0] rd_addr,
   output thls_pkg::rgb_type                                      texel
);

   localparam int ADDR_W = (TEX_TEXELS > 1) ? $clog2(TEX_TEXELS) : 1;

   thls_pkg::rgb_type          texel_mem_ff [TEX_TEXELS];
   thls_pkg::rgb_type          texel_ff;
   logic [ADDR_W+15:0]         wr_ext;
   logic [ADDR_W-1:0]          mem_addr;
   logic                       wr_en;

   always_comb begin
      wr_ext   = (ADDR_W+16)'(wr.addr);
      wr_en    = ctl.valid && (ctl.shade == thls_pkg::CMD_LOAD) &&
                 (32'(wr.addr) < 32'(TEX_TEXELS));
      mem_addr = ctl.shade ? rd_addr : wr_ext[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            texel_mem_ff[mem_addr] <= wr.rgb;
         end
         texel_ff <= texel_mem_ff[mem_addr];
      end
   end

   assign texel = texel_ff;

endmodule

// ----- hw/rtl/thls_color.sv -----
// ----------------------------------------------------------------------------
// thls_color
// scales texel bytes or grey by intensity into the result register
// ----------------------------------------------------------------------------
module thls_color (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  thls_pkg::ctl_type            ctl,
   input  thls_pkg::rgb_type            texel,
   input  logic [thls_pkg::INT_W-1:0]   inten,
   input  logic                         tex_on,
   output logic                         rsp_valid,
   output thls_pkg::rgb_type            rsp_rgb
);

   logic              rsp_valid_ff;
   thls_pkg::rgb_type rsp_rgb_ff, rsp_rgb_in;
   logic [7:0]        grey;

   always_comb begin
      grey = thls_pkg::scale_byte(8'hFF, inten);
      if (tex_on) begin
         rsp_rgb_in.red   = thls_pkg::scale_byte(texel.red, inten);
         rsp_rgb_in.green = thls_pkg::scale_byte(texel.green, inten);
         rsp_rgb_in.blue  = thls_pkg::scale_byte(texel.blue, inten);
      end else begin
         rsp_rgb_in.red   = grey;
         rsp_rgb_in.green = grey;
         rsp_rgb_in.blue  = grey;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl.valid && (ctl.shade == thls_pkg::CMD_SHADE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_rgb_ff <= rsp_rgb_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rgb   = rsp_rgb_ff;

endmodule

// ----- hw/rtl/textured_half_lambert_shade.sv -----
// ----------------------------------------------------------------------------
// textured_half_lambert_shade
// fixed-point half-lambert fragment shader with nearest-texel colour
//
//   channel | dir | handshake            | contents
//   req     | in  | req_tvalid/tready    | texel load or fragment to shade
//   rsp     | out | rsp_tvalid/tready    | rgb colour, one per shaded fragment
//   csr     | in  | csr_valid/ready      | register index and data
//
// one item per clock while the result is not stalled; a shade item reaches the
// result register through the multiplier stages, address wrap and texel memory read
// load items write the store in the memory stage and return nothing
// synchronous reset empties the pipeline; the texel store is not cleared
// the whole pipeline holds while a result waits and rsp_tready is low
// ----------------------------------------------------------------------------
module textured_half_lambert_shade #(
   parameter int TEX_DIM_MAX = 256,
   parameter int TEX_TEXELS  = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // texel_addr[15:0] texel_red[23:16] texel_green[31:24] texel_blue[39:32]
   // normal_x[55:40] normal_y[71:56] normal_z[87:72] coord_u[104:88]
   // coord_v[121:105], zero pad above
   input  logic [127:0]                          req_tdata,
   // cmd
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_red[7:0] out_green[15:8] out_blue[23:16]
   output logic [23:0]                           rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [thls_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [thls_pkg::CSR_DAT_W-1:0]        csr_data
);

   localparam int DIM_W  = $clog2(TEX_DIM_MAX + 1);
   localparam int ADDR_W = (TEX_TEXELS > 1) ? $clog2(TEX_TEXELS) : 1;

   logic                              en;
   logic signed [thls_pkg::VEC_W-1:0] light_x, light_y, light_z;
   logic signed [thls_pkg::VEC_W-1:0] normal_x, normal_y, normal_z;
   logic [thls_pkg::COORD_W-1:0]      coord_u, coord_v;
   logic [DIM_W-1:0]                  tex_w, tex_h;
   logic                              tex_on;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [thls_pkg::INT_W-1:0]        inten;
   thls_pkg::rgb_type                 texel, rsp_rgb;
   thls_pkg::wr_type                  wr_in;
   thls_pkg::ctl_type                 ctl_in;
   thls_pkg::ctl_type                 ctl_ff [thls_pkg::CTL_TAPS];
   thls_pkg::wr_type                  wr_ff  [thls_pkg::WR_TAPS];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_comb begin
      normal_x     = req_tdata[55:40];
      normal_y     = req_tdata[71:56];
      normal_z     = req_tdata[87:72];
      coord_u      = req_tdata[104:88];
      coord_v      = req_tdata[121:105];
      wr_in.addr   = req_tdata[15:0];
      wr_in.rgb.red   = req_tdata[23:16];
      wr_in.rgb.green = req_tdata[31:24];
      wr_in.rgb.blue  = req_tdata[39:32];
      ctl_in.valid = req_tvalid;
      ctl_in.shade = (req_tuser == thls_pkg::CMD_SHADE);
   end

   // item kind and valid travel beside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < thls_pkg::CTL_TAPS; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < thls_pkg::CTL_TAPS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr_ff[0] <= wr_in;
         for (int k = 1; k < thls_pkg::WR_TAPS; k++) begin
            wr_ff[k] <= wr_ff[k-1];
         end
      end
   end

   thls_csr #(
      .TEX_DIM_MAX (TEX_DIM_MAX)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .light_x   (light_x),
      .light_y   (light_y),
      .light_z   (light_z),
      .tex_w     (tex_w),
      .tex_h     (tex_h),
      .tex_on    (tex_on)
   );

   thls_light u_light (
      .clock    (clock),
      .en       (en),
      .normal_x (normal_x),
      .normal_y (normal_y),
      .normal_z (normal_z),
      .light_x  (light_x),
      .light_y  (light_y),
      .light_z  (light_z),
      .inten    (inten)
   );

   thls_addr #(
      .TEX_DIM_MAX (TEX_DIM_MAX),
      .TEX_TEXELS  (TEX_TEXELS)
   ) u_addr (
      .clock   (clock),
      .en      (en),
      .coord_u (coord_u),
      .coord_v (coord_v),
      .tex_w   (tex_w),
      .tex_h   (tex_h),
      .rd_addr (rd_addr)
   );

   thls_tex_mem #(
      .TEX_TEXELS (TEX_TEXELS)
   ) u_tex_mem (
      .clock   (clock),
      .en      (en),
      .ctl     (ctl_ff[thls_pkg::WR_TAPS-1]),
      .wr      (wr_ff[thls_pkg::WR_TAPS-1]),
      .rd_addr (rd_addr),
      .texel   (texel)
   );

   thls_color u_color (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl       (ctl_ff[thls_pkg::CTL_TAPS-1]),
      .texel     (texel),
      .inten     (inten),
      .tex_on    (tex_on),
      .rsp_valid (rsp_tvalid),
      .rsp_rgb   (rsp_rgb)
   );

   assign rsp_tdata = {rsp_rgb.blue, rsp_rgb.green, rsp_rgb.red};

endmodule

// ----- hw/rtl/thls_checker.sv -----
// ----------------------------------------------------------------------------
// thls_checker
// port-level checks on the shader's flow control and latency
// ----------------------------------------------------------------------------
`include "textured_half_lambert_shade_defines.svh"

module thls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `THLS_ASSERT_RESET(a_reset_empty, !rsp_tvalid, "result valid after reset")

   `THLS_ASSERT_SAME(a_ready_follows_output, 1'b1, req_tready == (!rsp_tvalid || rsp_tready), "request ready does not follow result register")

   `THLS_ASSERT_NEXT(a_result_held, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `THLS_ASSERT_SAME(a_result_origin, rsp_tvalid && $past(req_tready, 1) && $past(req_tready, 2) && $past(req_tready, 3) && $past(req_tready, 4) && $past(req_tready, 5) && $past(req_tready, 6) && $past(req_tready, 7), $past(req_tvalid && req_tready && req_tuser, 7), "result without a shade item seven cycles earlier")

endmodule

bind textured_half_lambert_shade thls_checker u_thls_checker (.*);

// ----- dv/tb_textured_half_lambert_shade.sv -----
// ----------------------------------------------------------------------------
// tb_textured_half_lambert_shade
// self-checking bench for the half-lambert fragment shader: texel loads and
// shade items go in on the request stream, every colour on the result stream
// is compared with a colour worked out in the bench from the register
// settings and its own copy of the texel store
// ----------------------------------------------------------------------------
module tb_textured_half_lambert_shade;

   localparam int STORE_DEPTH  = 65536;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 250;
   localparam logic [thls_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef struct {
      logic         user;
      logic [127:0] data;
   } req_item_type;

   class shade_scoreboard_type;
      logic signed [thls_pkg::VEC_W-1:0] light [3];
      logic [thls_pkg::DIM_REG_W-1:0]    width_reg;
      logic [thls_pkg::DIM_REG_W-1:0]    height_reg;
      logic                              tex_on;
      thls_pkg::rgb_type                 texels [STORE_DEPTH];
      thls_pkg::rgb_type                 colour_q [$];
      int                                errors;

      function new();
         light[0]   = '0;
         light[1]   = '0;
         light[2]   = thls_pkg::LIGHT_Z_RST;
         width_reg  = 9'd256;
         height_reg = 9'd256;
         tex_on     = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [thls_pkg::CSR_IDX_W-1:0] idx,
                              logic [thls_pkg::CSR_DAT_W-1:0] val);
         case (idx)
            thls_pkg::REG_LIGHT_X: light[0] = val;
            thls_pkg::REG_LIGHT_Y: light[1] = val;
            thls_pkg::REG_LIGHT_Z: light[2] = val;
            thls_pkg::REG_TEX_W:   width_reg = val[thls_pkg::DIM_REG_W-1:0];
            thls_pkg::REG_TEX_H:   height_reg = val[thls_pkg::DIM_REG_W-1:0];
            thls_pkg::REG_TEX_ON:  tex_on = val[0];
            default: ;
         endcase
      endfunction

      function int dim(logic [thls_pkg::DIM_REG_W-1:0] d);
         if (d == 0) return 1;
         if (d > 256) return 256;
         return int'(d);
      endfunction

      function int texel_index(logic [thls_pkg::COORD_W-1:0] c, int size);
         int i;
         i = (int'(c) * size) >>> 16;
         if (i > size - 1) i = size - 1;
         return i;
      endfunction

      function int fetch_addr(logic [thls_pkg::COORD_W-1:0] u,
                              logic [thls_pkg::COORD_W-1:0] v);
         int w;
         w = dim(width_reg);
         return (texel_index(v, dim(height_reg)) * w + texel_index(u, w)) % STORE_DEPTH;
      endfunction

      function void note_item(logic cmd, logic [127:0] d);
         logic signed [thls_pkg::VEC_W-1:0] nx, ny, nz;
         longint                            m;
         int                                inten;
         thls_pkg::rgb_type                 t, c;
         if (cmd == thls_pkg::CMD_LOAD) begin
            t.red   = d[23:16];
            t.green = d[31:24];
            t.blue  = d[39:32];
            texels[d[15:0]] = t;
            return;
         end
         nx = d[55:40];
         ny = d[71:56];
         nz = d[87:72];
         m = longint'(nx) * longint'(light[0]) + longint'(ny) * longint'(light[1])
           + longint'(nz) * longint'(light[2]);
         if (m < 0) m = 0;
         if (m > (longint'(1) << 28)) m = longint'(1) << 28;
         inten = int'((m + (longint'(1) << 28)) >>> 15);
         if (tex_on) begin
            t = texels[fetch_addr(d[104:88], d[121:105])];
            c.red   = 8'((int'(t.red) * inten) >>> 14);
            c.green = 8'((int'(t.green) * inten) >>> 14);
            c.blue  = 8'((int'(t.blue) * inten) >>> 14);
         end else begin
            c.red   = 8'((inten * 255) >>> 14);
            c.green = c.red;
            c.blue  = c.red;
         end
         colour_q.push_back(c);
      endfunction

      function void check_result(logic [23:0] d);
         thls_pkg::rgb_type c;
         if (colour_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected colour %h with nothing pending", d);
            return;
         end
         c = colour_q.pop_front();
         if (d[7:0] !== c.red || d[15:8] !== c.green || d[23:16] !== c.blue) begin
            errors++;
            if (errors <= 10)
               $display("colour mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        c.red, c.green, c.blue, d[7:0], d[15:8], d[23:16]);
         end
      endfunction

      function int pending();
         return colour_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [127:0]                   req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [23:0]                    rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [thls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [thls_pkg::CSR_DAT_W-1:0] csr_data = '0;

   shade_scoreboard_type sb = new();
   req_item_type         tx_q [$];
   bit                   loaded [STORE_DEPTH];
   int                   tx_idle = 35;
   int                   rx_idle = 46;
   int                   rx_hold = 0;
   int                   cycles = 0;

   textured_half_lambert_shade DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // result side: random stalls, plus a long hold-off when asked
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   function automatic logic signed [thls_pkg::VEC_W-1:0] rand_q14();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return thls_pkg::VEC_W'($urandom_range(32768)) - 16'sd16384;
      endcase
   endfunction

   function automatic logic [thls_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0: return 17'd65536;
         1: return 17'd0;
         default: return thls_pkg::COORD_W'($urandom_range(65536));
      endcase
   endfunction

   task automatic queue_texel_load(logic [15:0] addr, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b);
      req_item_type it;
      it.user = thls_pkg::CMD_LOAD;
      it.data = {6'b0, rand_coord(), rand_coord(), 16'($urandom), 16'($urandom),
                 16'($urandom), b, g, r, addr};
      tx_q.push_back(it);
      loaded[addr] = 1'b1;
   endtask

   // with a texture bound, the texel about to be fetched is loaded first unless already loaded
   task automatic queue_fragment(logic signed [thls_pkg::VEC_W-1:0] nx,
                                 logic signed [thls_pkg::VEC_W-1:0] ny,
                                 logic signed [thls_pkg::VEC_W-1:0] nz,
                                 logic [thls_pkg::COORD_W-1:0] u,
                                 logic [thls_pkg::COORD_W-1:0] v);
      req_item_type it;
      int           a;
      if (sb.tex_on) begin
         a = sb.fetch_addr(u, v);
         if (!loaded[a]) queue_texel_load(16'(a), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      it.user = thls_pkg::CMD_SHADE;
      it.data = {6'b0, v, u, nz, ny, nx, 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom)};
      tx_q.push_back(it);
   endtask

   task automatic send_items();
      while (tx_q.size() > 0) begin
         @(posedge clock);
         if (req_tvalid && req_tready) begin
            sb.note_item(req_tuser, req_tdata);
            tx_q.delete(0);
         end
         if (tx_q.size() > 0 && ((req_tvalid && !req_tready) ||
                                 $urandom_range(99) >= tx_idle)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= tx_q[0].user;
            req_tdata  <= tx_q[0].data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   endtask

   // loads return nothing, so allow the pipeline to empty after the last colour
   task automatic settle();
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(logic [thls_pkg::CSR_IDX_W-1:0] idx,
                              logic [thls_pkg::CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic set_light(logic signed [thls_pkg::VEC_W-1:0] x,
                            logic signed [thls_pkg::VEC_W-1:0] y,
                            logic signed [thls_pkg::VEC_W-1:0] z);
      program_reg(thls_pkg::REG_LIGHT_X, x);
      program_reg(thls_pkg::REG_LIGHT_Y, y);
      program_reg(thls_pkg::REG_LIGHT_Z, z);
   endtask

   task automatic set_texture(int w, int h, logic on);
      program_reg(thls_pkg::REG_TEX_W, thls_pkg::CSR_DAT_W'(w));
      program_reg(thls_pkg::REG_TEX_H, thls_pkg::CSR_DAT_W'(h));
      program_reg(thls_pkg::REG_TEX_ON, thls_pkg::CSR_DAT_W'(on));
   endtask

   task automatic random_items(int n);
      repeat (n) begin
         if ($urandom_range(99) < 30)
            queue_texel_load(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else
            queue_fragment(rand_q14(), rand_q14(), rand_q14(), rand_coord(), rand_coord());
      end
      send_items();
      settle();
   endtask

   initial begin : main
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: light along z, grey output
      queue_fragment(16'sd0, 16'sd0, 16'sd16384, 17'd0, 17'd0);
      queue_fragment(16'sd0, 16'sd0, -16'sd16384, 17'd0, 17'd0);
      queue_fragment(16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0);
      queue_fragment(-16'sd16384, 16'sd16384, 16'sd8192, 17'd65536, 17'd65536);
      send_items();
      settle();

      // dot product above one and negative dot product
      set_light(16'sd16384, 16'sd16384, 16'sd16384);
      queue_fragment(16'sd16384, 16'sd16384, 16'sd16384, 17'd0, 17'd0);
      queue_fragment(-16'sd16384, -16'sd16384, -16'sd16384, 17'd0, 17'd0);
      queue_fragment(16'sd16384, -16'sd16384, 16'sd100, 17'd0, 17'd0);
      send_items();
      settle();

      // single-texel texture, coordinates saturate, load just before a fetch
      set_light(-16'sd16384, 16'sd0, 16'sd0);
      set_texture(1, 1, 1'b1);
      queue_texel_load(16'd0, 8'd255, 8'd255, 8'd255);
      queue_fragment(-16'sd16384, 16'sd0, 16'sd0, 17'd0, 17'd0);
      queue_fragment(16'sd16384, 16'sd0, 16'sd0, 17'd65536, 17'd65536);
      queue_texel_load(16'd0, 8'd0, 8'd0, 8'd0);
      queue_fragment(-16'sd16384, 16'sd0, 16'sd0, 17'd65536, 17'd0);
      send_items();
      settle();

      // full-size texture, corner texels
      set_texture(256, 256, 1'b1);
      queue_texel_load(16'd0, 8'h55, 8'hAA, 8'hFF);
      queue_texel_load(16'd65535, 8'hFF, 8'h00, 8'hAA);
      queue_fragment(-16'sd16384, 16'sd0, 16'sd0, 17'd0, 17'd0);
      queue_fragment(-16'sd8192, 16'sd0, 16'sd0, 17'd65536, 17'd65536);
      queue_fragment(16'sd0, 16'sd0, 16'sd0, 17'd65535, 17'd0);
      queue_fragment(16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd65535);
      send_items();
      settle();

      set_light(rand_q14(), rand_q14(), rand_q14());
      set_texture(5, 3, 1'b1);
      random_items(180);

      set_light(-16'sd16384, -16'sd16384, -16'sd16384);
      set_texture(0, 300, 1'b1);
      random_items(180);

      tx_idle = 46;
      rx_idle = 35;
      set_light(rand_q14(), rand_q14(), rand_q14());
      set_texture(256, 256, 1'b1);
      random_items(180);

      set_light(rand_q14(), rand_q14(), rand_q14());
      set_texture(511, 17, 1'b0);
      program_reg(REG_SPARE, 16'hFFFF);
      random_items(180);

      tx_idle = 0;
      rx_idle = 0;
      set_light(16'sd16384, 16'sd16384, -16'sd16384);
      set_texture(16, 16, 1'b1);
      random_items(180);

      // receiver holds off while the sender keeps offering items
      rx_hold = HOLD_CYCLES;
      random_items(100);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/thls_pkg.sv
hw/rtl/thls_csr.sv
hw/rtl/thls_light.sv
hw/rtl/thls_addr.sv
hw/rtl/thls_tex_mem.sv
hw/rtl/thls_color.sv
hw/rtl/textured_half_lambert_shade.sv
hw/rtl/thls_checker.sv
dv/tb_textured_half_lambert_shade.sv
